>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that an implication holds in the cycle after its condition.
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, cond, prop)
`define ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif
`endif

>>> rtl/chm_pkg.sv
// Shared constants and codes of the chained hash map.
package chm_pkg;
    localparam int BUCKETS_DEF = 64;
    localparam int POOL_SIZE_DEF = 256;
    localparam int KEY_W = 31;
    localparam int DATA_W = 32;
    localparam logic [1:0] REQ_SET = 2'd0;
    localparam logic [1:0] REQ_GET = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
endpackage

>>> rtl/chm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns the old data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/chained_hash_map_core.sv
// Top level of the chained hash map: request sequencer and node memories.
//
// Each word on the s_ side is one request (set, get or remove); each
// request gives one result word on the m_ side. A request is handled
// alone by a sequencer that walks the bucket chain through synchronous
// memories with registered reads: it reads the bucket head, then visits
// the chain nodes in turn, writes back any change and hands the result
// over. After reset one clearing pass over max(BUCKETS, POOL_SIZE)
// addresses sets every bucket head to null and fills the free-node
// stack; no request is taken until it is done.
module chained_hash_map_core
    import chm_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: key[30:0], grade_bits[62:31], record_tag[94:63], zero fill
    input  logic [95:0]  s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: found[0], status[2:1], grade_out[34:3], tag_out[66:35],
    // entry_count[75:67], collision_count[83:76], zero fill
    output logic [87:0]  m_tdata
);
    localparam int PW = $clog2(POOL_SIZE);
    localparam int NW = $clog2(POOL_SIZE + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int INIT_LEN = (BUCKETS > POOL_SIZE) ? BUCKETS : POOL_SIZE;
    localparam int IW = $clog2(INIT_LEN + 1);
    localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2,
        S_HEADW = 4'd3, S_NODE = 4'd4, S_NODEW = 4'd5, S_ACT = 4'd6,
        S_FREE = 4'd7, S_OUT = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [IW-1:0] init_cnt_reg, init_cnt_next;
    logic [1:0] req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [DATA_W-1:0] grade_reg, tag_reg;
    logic [NW-1:0] cur_reg, prev_reg, head_reg;
    logic [NW-1:0] free_top_reg, free_top_next;
    logic [NW-1:0] total_reg, total_next;
    logic [NW-1:0] nonempty_reg, nonempty_next;
    logic found_reg;
    logic [1:0] status_reg;
    logic [DATA_W-1:0] gout_reg, tout_reg;
    logic [NW-1:0] steps_reg;

    logic [BW-1:0] bucket;
    // Bucket is key mod BUCKETS; handled as a small constant modulo.
    assign bucket = (BUCKETS > 1) ? BW'(key_reg % KEY_W'(BUCKETS)) : '0;

    // Memory ports
    logic hd_we; logic [BW-1:0] hd_wa, hd_ra; logic [NW-1:0] hd_wd, hd_rd;
    logic nd_we; logic [PW-1:0] nd_wa, nd_ra;
    logic [KEY_W+2*DATA_W-1:0] nd_wd, nd_rd;
    logic nx_we; logic [PW-1:0] nx_wa, nx_ra; logic [NW-1:0] nx_wd, nx_rd;
    logic fs_we; logic [PW-1:0] fs_wa, fs_ra, fs_wd, fs_rd;

    chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (.aclk, .we(hd_we),
        .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    chm_ram #(.WIDTH(KEY_W+2*DATA_W), .DEPTH(POOL_SIZE)) u_node (.aclk,
        .we(nd_we), .waddr(nd_wa), .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd));
    chm_ram #(.WIDTH(NW), .DEPTH(POOL_SIZE)) u_next (.aclk, .we(nx_we),
        .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    chm_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_free (.aclk, .we(fs_we),
        .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

    logic [KEY_W-1:0] nd_key;
    logic [DATA_W-1:0] nd_grade, nd_tag;
    assign nd_key = nd_rd[KEY_W-1:0];
    assign nd_grade = nd_rd[KEY_W+DATA_W-1:KEY_W];
    assign nd_tag = nd_rd[KEY_W+2*DATA_W-1:KEY_W+DATA_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {4'd0, 8'(total_reg - nonempty_reg), 9'(total_reg),
                      tout_reg, gout_reg, status_reg, found_reg};

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;
    logic is_set, is_rem;
    assign is_set = (req_reg == REQ_SET);
    assign is_rem = (req_reg == REQ_REMOVE);

    // Memory control and next state
    always_comb begin
        state_next = state_reg;
        init_cnt_next = init_cnt_reg;
        free_top_next = free_top_reg;
        total_next = total_reg;
        nonempty_next = nonempty_reg;
        hd_we = 1'b0; hd_wa = bucket; hd_wd = NIL; hd_ra = bucket;
        nd_we = 1'b0; nd_wa = '0; nd_wd = {tag_reg, grade_reg, key_reg};
        nd_ra = cur_reg[PW-1:0];
        nx_we = 1'b0; nx_wa = '0; nx_wd = head_reg; nx_ra = cur_reg[PW-1:0];
        fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
        fs_ra = PW'(free_top_reg - NW'(1));
        unique case (state_reg)
            S_INIT: begin
                // Clear bucket heads and fill the free stack
                if (init_cnt_reg < IW'(BUCKETS)) begin
                    hd_we = 1'b1; hd_wa = BW'(init_cnt_reg);
                end
                if (init_cnt_reg < IW'(POOL_SIZE)) begin
                    fs_we = 1'b1; fs_wa = PW'(init_cnt_reg);
                    fs_wd = PW'(init_cnt_reg);
                end
                init_cnt_next = init_cnt_reg + IW'(1);
                if (init_cnt_reg == IW'(INIT_LEN - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: if (in_acc) state_next = S_HEAD;
            S_HEAD: state_next = S_HEADW;
            S_HEADW: begin
                if (hd_rd == NIL) state_next = S_ACT;
                else state_next = S_NODE;
            end
            S_NODE: state_next = S_NODEW;
            S_NODEW: begin
                if (nd_key == key_reg) state_next = S_ACT;
                else if (nx_rd == NIL || steps_reg == NW'(POOL_SIZE - 1))
                    state_next = S_ACT;
                else state_next = S_NODE;
            end
            S_ACT: begin
                state_next = S_OUT;
                if (found_reg) begin
                    if (is_set) begin
                        nd_we = 1'b1; nd_wa = cur_reg[PW-1:0];
                        nd_wd = {tag_reg, grade_reg, key_reg};
                    end else if (is_rem) begin
                        // Unlink the node and push it on the free stack
                        if (prev_reg == NIL) begin
                            hd_we = 1'b1; hd_wd = nx_rd;
                            if (nx_rd == NIL && nonempty_reg != '0)
                                nonempty_next = nonempty_reg - NW'(1);
                        end else begin
                            nx_we = 1'b1; nx_wa = prev_reg[PW-1:0]; nx_wd = nx_rd;
                        end
                        if (free_top_reg < NW'(POOL_SIZE)) begin
                            fs_we = 1'b1; fs_wa = free_top_reg[PW-1:0];
                            fs_wd = cur_reg[PW-1:0];
                            free_top_next = free_top_reg + NW'(1);
                        end
                        if (total_reg != '0) total_next = total_reg - NW'(1);
                    end
                end else if (is_set && free_top_reg != '0) begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                // Stack top read is ready: fill and link the new node
                nd_we = 1'b1; nd_wa = fs_rd;
                nx_we = 1'b1; nx_wa = fs_rd; nx_wd = head_reg;
                hd_we = 1'b1; hd_wd = NW'(fs_rd);
                if (head_reg == NIL) nonempty_next = nonempty_reg + NW'(1);
                free_top_next = free_top_reg - NW'(1);
                total_next = total_reg + NW'(1);
                state_next = S_OUT;
            end
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_cnt_reg <= '0;
            free_top_reg <= NW'(POOL_SIZE);
            total_reg <= '0;
            nonempty_reg <= '0;
        end else begin
            state_reg <= state_next;
            init_cnt_reg <= init_cnt_next;
            free_top_reg <= free_top_next;
            total_reg <= total_next;
            nonempty_reg <= nonempty_next;
        end
    end

    // Request and walk registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (in_acc) begin
                req_reg <= s_tuser;
                key_reg <= s_tdata[30:0];
                grade_reg <= s_tdata[62:31];
                tag_reg <= s_tdata[94:63];
                found_reg <= 1'b0;
                prev_reg <= NIL;
                steps_reg <= '0;
            end
            S_HEADW: begin
                head_reg <= hd_rd;
                cur_reg <= hd_rd;
            end
            S_NODEW: begin
                if (nd_key == key_reg) begin
                    found_reg <= 1'b1;
                    gout_reg <= nd_grade;
                    tout_reg <= nd_tag;
                end else begin
                    prev_reg <= cur_reg;
                    cur_reg <= nx_rd;
                    steps_reg <= steps_reg + NW'(1);
                end
            end
            S_ACT: begin
                status_reg <= ST_OK;
                if (found_reg) begin
                    if (is_set) begin
                        gout_reg <= grade_reg; tout_reg <= tag_reg;
                    end
                end else begin
                    gout_reg <= '0; tout_reg <= '0;
                    if (!is_set) status_reg <= ST_MISS;
                    else if (free_top_reg == '0) status_reg <= ST_FULL;
                end
            end
            S_FREE: begin
                gout_reg <= grade_reg; tout_reg <= tag_reg;
            end
            default: begin
            end
        endcase
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, s_tready == 1'b0)
    `ASSERT_IMPL(a_total_bound, aclk, aresetn, 1'b1, total_reg <= NW'(POOL_SIZE))
    `ASSERT_IMPL(a_pool_sum, aclk, aresetn, state_reg == S_IDLE,
        total_reg + free_top_reg == NW'(POOL_SIZE))
    `ASSERT_IMPL(a_nonempty, aclk, aresetn, 1'b1, nonempty_reg <= total_reg)
endmodule
